### hdl/imucaf_pkg.sv
// ----------------------------------------------------------------------------
// IMU attitude filter package
// Shared constants, control types and arithmetic helpers for the filter.
// ----------------------------------------------------------------------------
`default_nettype none

package imucaf_pkg;

   // Default build values.
   localparam int DEF_CORDIC_STEPS    = 16;
   localparam int DEF_ANGLE_FRAC_BITS = 16;

   // Sequencer count width; covers the CORDIC passes and the divider digits.
   localparam int CNT_W = 7;

   // Gyro scale: 131 counts per deg/s and 1000 ms per second.
   localparam logic [16:0] GYRO_DIV  = 17'd131000;
   localparam logic [16:0] GYRO_HALF = 17'd65500;

   // Divider digit width and the matching reciprocal ceil(2^48 / 131000).
   // A partial dividend stays below 131000 * 2^14 < 2^31, where the
   // reciprocal product shifted down by 48 gives the exact quotient digit.
   localparam int          DIG_W      = 14;
   localparam logic [31:0] GYRO_RECIP = 32'd2148663945;

   // CORDIC constants.
   localparam logic [29:0]        INV_GAIN_Q30 = 30'd652032874;
   localparam logic signed [35:0] DEG180_Q24   = 36'sd3019898880;

   // Blend weight limits.
   localparam logic [15:0] BLEND_ONE   = 16'd32768;
   localparam logic [15:0] BLEND_RESET = 16'd32113;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_GMUL,
      OP_DINIT,
      OP_DMUL,
      OP_DSTEP,
      OP_GADD,
      OP_CINIT,
      OP_CSTEP,
      OP_MMUL,
      OP_MEND,
      OP_CEND,
      OP_BMULG,
      OP_BMULA,
      OP_BLEND,
      OP_OUT
   } op_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      op_type           op;
      logic [1:0]       axis;  // gyro axis: 0 pitch/X, 1 roll/Y, 2 yaw/Z
      logic             sel;   // CORDIC: 0 roll vector, 1 pitch vector; blend: 0 pitch, 1 roll
      logic [CNT_W-1:0] idx;   // CORDIC iteration number
   } cmd_type;

   // atan(2^-i) in degrees, Q8.24.
   function automatic logic [30:0] atan_q24(input logic [4:0] i);
      logic [30:0] r;
      case (i)
         5'd0:  r = 31'd754974720;
         5'd1:  r = 31'd445687602;
         5'd2:  r = 31'd235489088;
         5'd3:  r = 31'd119537938;
         5'd4:  r = 31'd60000934;
         5'd5:  r = 31'd30029717;
         5'd6:  r = 31'd15018523;
         5'd7:  r = 31'd7509720;
         5'd8:  r = 31'd3754917;
         5'd9:  r = 31'd1877466;
         5'd10: r = 31'd938734;
         5'd11: r = 31'd469367;
         5'd12: r = 31'd234684;
         5'd13: r = 31'd117342;
         5'd14: r = 31'd58671;
         5'd15: r = 31'd29335;
         5'd16: r = 31'd14668;
         5'd17: r = 31'd7334;
         5'd18: r = 31'd3667;
         5'd19: r = 31'd1833;
         5'd20: r = 31'd917;
         5'd21: r = 31'd458;
         5'd22: r = 31'd229;
         5'd23: r = 31'd115;
         default: r = 31'd0;
      endcase
      return r;
   endfunction

   // Clamp to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
      logic signed [31:0] r;
      if (v > 51'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -51'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/imucaf_ctrl.sv
// ----------------------------------------------------------------------------
// IMU attitude filter controller
// Sequences the gyro integration, the two CORDIC passes and the blends.
// ----------------------------------------------------------------------------
`default_nettype none

module imucaf_ctrl import imucaf_pkg::*; #(
   parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
   parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   input  wire logic    req_sample_valid,
   output logic         req_tready,
   input  wire logic    rsp_tready,
   output logic         rsp_tvalid,
   output cmd_type      cmd
);

   localparam int NUM_W = 48 + ANGLE_FRAC_BITS;
   localparam int NDIG  = (NUM_W + DIG_W - 1) / DIG_W;

   typedef enum logic [16:0] {
      S_IDLE   = 17'h00001,
      S_GMUL   = 17'h00002,
      S_DINIT  = 17'h00004,
      S_DSTEP  = 17'h00008,
      S_GADD   = 17'h00010,
      S_C1INIT = 17'h00020,
      S_C1STEP = 17'h00040,
      S_MMUL   = 17'h00080,
      S_MEND   = 17'h00100,
      S_C2INIT = 17'h00200,
      S_C2STEP = 17'h00400,
      S_C2END  = 17'h00800,
      S_BMULG  = 17'h01000,
      S_BMULA  = 17'h02000,
      S_BLEND  = 17'h04000,
      S_OUT    = 17'h08000,
      S_DMUL   = 17'h10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       axis_ff, axis_in;
   logic             sel_ff, sel_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             slot_free;

   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and counters.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            axis_in = 2'd0;
            sel_in  = 1'b0;
            cnt_in  = '0;
            if (accept) begin
               state_in = req_sample_valid ? S_GMUL : S_OUT;
            end
         end
         S_GMUL:  state_in = S_DINIT;
         S_DINIT: state_in = S_DMUL;
         S_DMUL:  state_in = S_DSTEP;
         S_DSTEP: begin
            if (cnt_ff == CNT_W'(NDIG - 1)) begin
               cnt_in   = '0;
               state_in = S_GADD;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_DMUL;
            end
         end
         S_GADD: begin
            if (axis_ff == 2'd2) begin
               state_in = S_C1INIT;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_GMUL;
            end
         end
         S_C1INIT: state_in = S_C1STEP;
         S_C1STEP: begin
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_MMUL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_MMUL:   state_in = S_MEND;
         S_MEND:   state_in = S_C2INIT;
         S_C2INIT: state_in = S_C2STEP;
         S_C2STEP: begin
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_C2END;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_C2END: state_in = S_BMULG;
         S_BMULG: state_in = S_BMULA;
         S_BMULA: state_in = S_BLEND;
         S_BLEND: begin
            if (sel_ff) begin
               state_in = S_OUT;
            end else begin
               sel_in   = 1'b1;
               state_in = S_BMULG;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Command decode.
   always_comb begin
      cmd.op   = OP_NONE;
      cmd.axis = axis_ff;
      cmd.sel  = sel_ff;
      cmd.idx  = cnt_ff;
      unique case (state_ff)
         S_IDLE:   cmd.op = accept ? OP_LOAD : OP_NONE;
         S_GMUL:   cmd.op = OP_GMUL;
         S_DINIT:  cmd.op = OP_DINIT;
         S_DMUL:   cmd.op = OP_DMUL;
         S_DSTEP:  cmd.op = OP_DSTEP;
         S_GADD:   cmd.op = OP_GADD;
         S_C1INIT: begin
            cmd.op  = OP_CINIT;
            cmd.sel = 1'b0;
         end
         S_C1STEP: cmd.op = OP_CSTEP;
         S_MMUL:   cmd.op = OP_MMUL;
         S_MEND:   cmd.op = OP_MEND;
         S_C2INIT: begin
            cmd.op  = OP_CINIT;
            cmd.sel = 1'b1;
         end
         S_C2STEP: cmd.op = OP_CSTEP;
         S_C2END:  cmd.op = OP_CEND;
         S_BMULG:  cmd.op = OP_BMULG;
         S_BMULA:  cmd.op = OP_BMULA;
         S_BLEND:  cmd.op = OP_BLEND;
         S_OUT:    cmd.op = slot_free ? OP_OUT : OP_NONE;
         default:  cmd.op = OP_NONE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= 2'd0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### hdl/imucaf_dp.sv
// ----------------------------------------------------------------------------
// IMU attitude filter datapath
// Shared multiplier, digit-wise reciprocal divider, CORDIC vectoring unit and
// angle state.
// ----------------------------------------------------------------------------
`default_nettype none

module imucaf_dp import imucaf_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   input  wire logic [127:0] req_tdata,
   input  wire logic         req_sample_valid,
   input  wire logic         csr_valid,
   input  wire logic [15:0]  csr_data,
   output logic [95:0]       rsp_tdata,
   output logic              rsp_status
);

   localparam int NUM_W = 48 + ANGLE_FRAC_BITS;
   localparam int NDIG  = (NUM_W + DIG_W - 1) / DIG_W;
   localparam int NPAD  = NDIG * DIG_W;
   localparam int X_W   = 34;
   localparam int Z_W   = 36;
   localparam logic signed [Z_W-1:0] Z_RND = Z_W'(1) << (23 - ANGLE_FRAC_BITS);

   // Architectural state.
   logic signed [31:0] roll_ff, pitch_ff, yaw_ff;
   logic [31:0]        last_time_ff;
   logic [15:0]        blend_weight_ff;

   // Sample registers.
   logic signed [15:0] ax_ff, ay_ff, az_ff, gx_ff, gy_ff, gz_ff;
   logic [31:0]        delta_ff;
   logic [15:0]        w_ff;
   logic               stat_ff;

   // Working registers.
   logic signed [65:0]    prod_ff;
   logic [NPAD-1:0]       num_ff;
   logic [16:0]           rem_ff;
   logic signed [31:0]    pg_ff, rg_ff;
   logic signed [X_W-1:0] x_ff, y_ff;
   logic signed [Z_W-1:0] z_ff;
   logic                  zero_ff;
   logic signed [32:0]    m_ff;
   logic signed [31:0]    acc_roll_ff, acc_pitch_ff;
   logic signed [49:0]    bl_ff;
   logic [95:0]           rsp_data_ff;
   logic                  rsp_stat_ff;

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_status = rsp_stat_ff;

   // Gyro operand of the current axis.
   logic signed [15:0] g_sel;
   logic [15:0]        g_abs;
   always_comb begin
      case (cmd.axis)
         2'd0:    g_sel = gx_ff;
         2'd1:    g_sel = gy_ff;
         default: g_sel = gz_ff;
      endcase
      g_abs = g_sel[15] ? 16'(-g_sel) : g_sel;
   end

   // Partial dividend: the running remainder followed by the next digit.
   logic [30:0] div_t;
   logic [13:0] div_q;
   logic [30:0] div_qd;
   logic [30:0] div_r;
   always_comb begin
      div_t  = {rem_ff, num_ff[NPAD-1 -: DIG_W]};
      div_q  = prod_ff[61:48];
      div_qd = {17'b0, div_q} * {14'b0, GYRO_DIV};
      div_r  = div_t - div_qd;
   end

   // Shared multiplier operand selection.
   logic signed [32:0] mul_a, mul_b;
   logic               mul_en;
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      case (cmd.op)
         OP_GMUL: begin
            mul_a = {17'b0, g_abs};
            mul_b = {1'b0, delta_ff};
         end
         OP_DMUL: begin
            mul_a = {2'b0, div_t};
            mul_b = {1'b0, GYRO_RECIP};
         end
         OP_MMUL: begin
            mul_a = {1'b0, x_ff[31:0]};
            mul_b = {3'b0, INV_GAIN_Q30};
         end
         OP_BMULG: begin
            mul_a = {17'b0, w_ff};
            mul_b = 33'(cmd.sel ? rg_ff : pg_ff);
         end
         OP_BMULA: begin
            mul_a = {17'b0, 16'(BLEND_ONE - w_ff)};
            mul_b = 33'(cmd.sel ? acc_roll_ff : acc_pitch_ff);
         end
         default: mul_en = 1'b0;
      endcase
   end

   // Saturating gyro accumulation.
   logic [32:0]        inc_c;
   logic signed [31:0] g_base;
   logic signed [34:0] g_sum;
   always_comb begin
      inc_c = (|num_ff[NPAD-1:33]) ? '1 : num_ff[32:0];
      case (cmd.axis)
         2'd0:    g_base = pitch_ff;
         2'd1:    g_base = roll_ff;
         default: g_base = yaw_ff;
      endcase
      if (g_sel[15]) begin
         g_sum = 35'(g_base) - $signed({2'b0, inc_c});
      end else begin
         g_sum = 35'(g_base) + $signed({2'b0, inc_c});
      end
   end

   // CORDIC start vector with the left-half pre-rotation.
   logic signed [X_W-1:0] xi, yi;
   logic signed [X_W-1:0] ax_s;
   always_comb begin
      ax_s = {{(X_W-30){ax_ff[15]}}, ax_ff, 14'b0};
      if (cmd.sel) begin
         xi = X_W'(m_ff);
         yi = -ax_s;
      end else begin
         xi = {{(X_W-30){az_ff[15]}}, az_ff, 14'b0};
         yi = {{(X_W-30){ay_ff[15]}}, ay_ff, 14'b0};
      end
   end

   // CORDIC iteration.
   logic [4:0]            sh;
   logic signed [X_W-1:0] dx, dy;
   logic signed [Z_W-1:0] at;
   always_comb begin
      sh = cmd.idx[4:0];
      dx = y_ff >>> sh;
      dy = x_ff >>> sh;
      at = Z_W'(atan_q24(sh));
   end

   // Angle rounding to the output fraction.
   logic signed [Z_W-1:0] z_rnd;
   logic signed [31:0]    z_ang;
   always_comb begin
      z_rnd = (z_ff + Z_RND) >>> (24 - ANGLE_FRAC_BITS);
      z_ang = zero_ff ? 32'sd0 : z_rnd[31:0];
   end

   // Magnitude gain correction and blend sum.
   logic signed [65:0] m_rnd;
   logic signed [50:0] bsum;
   always_comb begin
      m_rnd = prod_ff + 66'sd536870912;
      bsum  = (51'(bl_ff) + 51'($signed(prod_ff[49:0])) + 51'sd16384) >>> 15;
   end

   // Architectural state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         roll_ff         <= '0;
         pitch_ff        <= '0;
         yaw_ff          <= '0;
         last_time_ff    <= '0;
         blend_weight_ff <= BLEND_RESET;
      end else begin
         if (csr_valid) begin
            blend_weight_ff <= csr_data;
         end
         if (cmd.op == OP_LOAD && req_sample_valid) begin
            last_time_ff <= req_tdata[127:96];
         end
         if (cmd.op == OP_GADD && cmd.axis == 2'd2) begin
            yaw_ff <= sat32(51'(g_sum));
         end
         if (cmd.op == OP_BLEND) begin
            if (cmd.sel) begin
               roll_ff <= sat32(bsum);
            end else begin
               pitch_ff <= sat32(bsum);
            end
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      case (cmd.op)
         OP_LOAD: begin
            ax_ff    <= req_tdata[15:0];
            ay_ff    <= req_tdata[31:16];
            az_ff    <= req_tdata[47:32];
            gx_ff    <= req_tdata[63:48];
            gy_ff    <= req_tdata[79:64];
            gz_ff    <= req_tdata[95:80];
            delta_ff <= req_tdata[127:96] - last_time_ff;
            w_ff     <= (blend_weight_ff > BLEND_ONE) ? BLEND_ONE : blend_weight_ff;
            stat_ff  <= !req_sample_valid;
         end
         OP_DINIT: begin
            num_ff <= NPAD'({prod_ff[46:0], {ANGLE_FRAC_BITS{1'b0}}}) + NPAD'(GYRO_HALF);
            rem_ff <= '0;
         end
         // One quotient digit per step; the remainder carries into the next.
         OP_DSTEP: begin
            rem_ff <= div_r[16:0];
            num_ff <= {num_ff[NPAD-DIG_W-1:0], div_q};
         end
         OP_GADD: begin
            if (cmd.axis == 2'd0) begin
               pg_ff <= sat32(51'(g_sum));
            end else if (cmd.axis == 2'd1) begin
               rg_ff <= sat32(51'(g_sum));
            end
         end
         OP_CINIT: begin
            zero_ff <= (xi == '0) && (yi == '0);
            if (xi < 0) begin
               x_ff <= -xi;
               y_ff <= -yi;
               z_ff <= (yi >= 0) ? DEG180_Q24 : -DEG180_Q24;
            end else begin
               x_ff <= xi;
               y_ff <= yi;
               z_ff <= '0;
            end
         end
         OP_CSTEP: begin
            if (y_ff > 0) begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + at;
            end else begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - at;
            end
         end
         OP_MMUL:  acc_roll_ff <= z_ang;
         OP_MEND:  m_ff <= zero_ff ? 33'sd0 : m_rnd[62:30];
         OP_CEND:  acc_pitch_ff <= z_ang;
         OP_BMULA: bl_ff <= prod_ff[49:0];
         OP_OUT: begin
            rsp_data_ff <= {yaw_ff, pitch_ff, roll_ff};
            rsp_stat_ff <= stat_ff;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### hdl/imu_complementary_attitude_filter.sv
// A valid sample passes through the gyro integration, both CORDIC passes and the blends;
// an invalid sample goes straight to the result register.
// One request at a time: the gyro divider (three passes, one per axis, in 14-bit digits)
// and the CORDIC unit (two passes) take most of the work. The result register frees the input early.
// Reset clears the angles, the last timestamp and sets the blend weight to 0.98.
// ----------------------------------------------------------------------------
// IMU complementary attitude filter
// Fuses gyro integration with accelerometer tilt into roll, pitch and yaw.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_complementary_attitude_filter import imucaf_pkg::*; #(
   parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
   parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_ms
   input  wire logic [127:0] req_tdata,
   // sample_valid
   input  wire logic [0:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // roll_deg, pitch_deg, yaw_deg
   output logic [95:0]       rsp_tdata,
   // status
   output logic [0:0]        rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [15:0]  csr_data
);

   cmd_type cmd;
   logic    status;

   assign csr_ready    = 1'b1;
   assign rsp_tuser[0] = status;

   // Sequencer.
   imucaf_ctrl #(
      .CORDIC_STEPS    (CORDIC_STEPS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_sample_valid (req_tuser[0]),
      .req_tready       (req_tready),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .cmd              (cmd)
   );

   // Arithmetic and state.
   imucaf_dp #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_tdata        (req_tdata),
      .req_sample_valid (req_tuser[0]),
      .csr_valid        (csr_valid && csr_ready),
      .csr_data         (csr_data),
      .rsp_tdata        (rsp_tdata),
      .rsp_status       (status)
   );

   // A request is taken only when the block is free, then it holds off.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // Sample capture happens only on an accepted request.
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_LOAD |-> req_tvalid && req_tready)
      else $error("capture without accepted request");

   // Loading the result register presents a result in the next cycle.
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_OUT |=> rsp_tvalid)
      else $error("result not presented");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Attitude filter testbench
// Streams inertial samples into the filter with random gaps on both channels.
// Results with no hand-computed value are checked against a behavioral model of
// gyro integration, CORDIC tilt and blend, kept in step with the weight writes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import imucaf_pkg::*;

   localparam int  FRAC        = 16;
   localparam int  STEPS       = 16;
   localparam int  NUM_PHASES  = 5;
   localparam int  PHASE_ITEMS = 330;
   localparam int  DRAIN_WAIT  = 300;
   localparam longint CYCLE_LIMIT = 4000000;

   // One sensor sample, with an optional hand-computed result.
   typedef struct packed {
      logic signed [15:0] ax, ay, az, gx, gy, gz;
      logic [31:0]        tm;
      logic               ok;
      logic               chk;
      logic [31:0]        roll, pitch, yaw;
      logic               st;
   } sample_row_t;

   typedef struct packed {
      logic [31:0] roll, pitch, yaw;
      logic        st;
   } attitude_t;

   localparam int NUM_ROWS = 17;
   sample_row_t dir_rows [NUM_ROWS] = '{
      // Read error right after reset reports the zero angles.
      '{0, 0, 0, 0, 0, 0, 32'd0, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0, 1'b1},
      // Zero vector at time zero leaves every angle at zero.
      '{0, 0, 0, 0, 0, 0, 32'd0, 1'b1, 1'b1, 32'd0, 32'd0, 32'd0, 1'b0},
      '{-32768, 0, 0, 0, 0, 0, 32'd10, 1'b1, 1'b0, 0, 0, 0, 0},
      '{32767, 0, 0, 0, 0, 0, 32'd11, 1'b1, 1'b0, 0, 0, 0, 0},
      '{0, 32767, 0, 0, 0, 0, 32'd12, 1'b1, 1'b0, 0, 0, 0, 0},
      '{0, -32768, 0, 0, 0, 0, 32'd13, 1'b1, 1'b0, 0, 0, 0, 0},
      // Negative z with zero y: the roll tilt lands on +180 degrees.
      '{0, 0, -32768, 0, 0, 0, 32'd14, 1'b1, 1'b0, 0, 0, 0, 0},
      '{0, 0, 32767, 0, 0, 0, 32'd15, 1'b1, 1'b0, 0, 0, 0, 0},
      '{0, 0, 16384, 32767, -32768, 32767, 32'd1000, 1'b1, 1'b0, 0, 0, 0, 0},
      '{0, 0, 16384, -32768, 32767, -32768, 32'd1001, 1'b1, 1'b0, 0, 0, 0, 0},
      '{1234, -99, 777, 32767, 32767, 32767, 32'd5000, 1'b0, 1'b0, 0, 0, 0, 0},
      // Huge time steps drive the integrated angles into saturation.
      '{0, 0, 16384, 32767, 32767, 32767, 32'hFFFF_FFFF, 1'b1, 1'b0, 0, 0, 0, 0},
      '{0, 0, 16384, -32768, -32768, -32768, 32'h7FFF_FFFF, 1'b1, 1'b0, 0, 0, 0, 0},
      // Timestamp wrap produces a large forward step.
      '{100, 200, 300, 5, -5, 5, 32'd5, 1'b1, 1'b0, 0, 0, 0, 0},
      '{-32768, -32768, -32768, -32768, -32768, -32768, 32'd6, 1'b1, 1'b0, 0, 0, 0, 0},
      '{32767, 32767, 32767, 32767, 32767, 32767, 32'd7, 1'b1, 1'b0, 0, 0, 0, 0},
      '{-1, -1, -1, -1, -1, -1, 32'hFFFF_FFFF, 1'b0, 1'b0, 0, 0, 0, 0}
   };

   longint atan_table [24] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115
   };

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [127:0]  req_tdata;
   logic [0:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [95:0]   rsp_tdata;
   logic [0:0]    rsp_tuser;
   logic          csr_valid;
   logic          csr_ready;
   logic [15:0]   csr_data;

   // Filter state mirrored by the testbench.
   logic signed [31:0] mdl_roll, mdl_pitch, mdl_yaw;
   logic [31:0]        mdl_last_time;
   logic [15:0]        mdl_weight;

   attitude_t pending_attitudes [$];
   int        error_count;
   longint    cycle_count;
   bit        rsp_busy_free;

   imu_complementary_attitude_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll_pick;
      roll_pick = $urandom_range(0, 99);
      if (roll_pick < 55) return 0;
      if (roll_pick < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [31:0] clamp_angle(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Gyro rate times elapsed ms, scaled to degrees, rounded half away from zero.
   function automatic longint gyro_step(input longint rate, input logic [31:0] dt_ms);
      longint unsigned mag, quo, rem, inc;
      mag = longint'(rate < 0 ? -rate : rate) * longint'({32'd0, dt_ms});
      quo = mag / 131000;
      rem = mag % 131000;
      inc = (quo << FRAC) + ((rem << FRAC) + 65500) / 131000;
      return rate < 0 ? -longint'(inc) : longint'(inc);
   endfunction

   // Vectoring CORDIC: returns atan2(y, x) in degrees and the corrected length.
   function automatic longint tilt_atan2(input longint x, input longint y,
                                         output longint len);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) begin
         len = 0;
         return 0;
      end
      if (x < 0) begin
         z = (y >= 0) ? 64'sd3019898880 : -64'sd3019898880;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x = x + dx; y = y - dy; z = z + atan_table[i];
         end else begin
            x = x - dx; y = y + dy; z = z - atan_table[i];
         end
      end
      len = (x * 64'sd652032874 + (64'sd1 <<< 29)) >>> 30;
      return (z + (64'sd1 <<< (23 - FRAC))) >>> (24 - FRAC);
   endfunction

   function automatic logic signed [31:0] mix_angle(input logic signed [31:0] gyro_ang,
                                                    input longint acc_ang,
                                                    input longint wt);
      longint s;
      s = wt * longint'(gyro_ang) + (32768 - wt) * acc_ang + 16384;
      return clamp_angle(s >>> 15);
   endfunction

   // Advances the mirrored state by one sample and returns the expected attitude.
   function automatic attitude_t advance_attitude(input sample_row_t s);
      attitude_t r;
      logic [31:0] dt_ms;
      logic signed [31:0] pg, rg;
      longint wt, acc_roll, acc_pitch, len, unused_len;
      if (s.ok) begin
         dt_ms = s.tm - mdl_last_time;
         mdl_last_time = s.tm;
         wt = (mdl_weight > 16'd32768) ? 32768 : longint'(mdl_weight);
         pg = clamp_angle(longint'(mdl_pitch) + gyro_step(longint'(s.gx), dt_ms));
         rg = clamp_angle(longint'(mdl_roll) + gyro_step(longint'(s.gy), dt_ms));
         mdl_yaw = clamp_angle(longint'(mdl_yaw) + gyro_step(longint'(s.gz), dt_ms));
         acc_roll = tilt_atan2(longint'(s.az) * 16384, longint'(s.ay) * 16384, len);
         acc_pitch = tilt_atan2(len, -longint'(s.ax) * 16384, unused_len);
         mdl_pitch = mix_angle(pg, acc_pitch, wt);
         mdl_roll = mix_angle(rg, acc_roll, wt);
         r.st = 1'b0;
      end else begin
         r.st = 1'b1;
      end
      r.roll = mdl_roll;
      r.pitch = mdl_pitch;
      r.yaw = mdl_yaw;
      return r;
   endfunction

   // Offers one request and waits for it to be taken, then may idle for a random gap.
   task automatic send_sample(input sample_row_t s, input bit no_idle);
      attitude_t pred;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {s.tm, s.gz, s.gy, s.gx, s.az, s.ay, s.ax};
      req_tuser <= s.ok;
      do @(posedge clock); while (!req_tready);
      pred = advance_attitude(s);
      if (s.chk) begin
         pred.roll = s.roll;
         pred.pitch = s.pitch;
         pred.yaw = s.yaw;
         pred.st = s.st;
      end
      pending_attitudes.push_back(pred);
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Weight writes only happen once every result has come back.
   task automatic write_weight(input logic [15:0] wt);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_attitudes.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= wt;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mdl_weight = wt;
   endtask

   function automatic logic signed [15:0] rand_axis();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return 16'sh8000;
      if (pick == 1) return 16'sh7FFF;
      if (pick < 6) return $urandom_range(0, 2000) - 1000;
      return $urandom_range(0, 65535);
   endfunction

   function automatic sample_row_t rand_sample();
      sample_row_t s;
      int pick;
      s = '0;
      s.ax = rand_axis(); s.ay = rand_axis(); s.az = rand_axis();
      s.gx = rand_axis(); s.gy = rand_axis(); s.gz = rand_axis();
      pick = $urandom_range(0, 99);
      if (pick < 85) s.tm = mdl_last_time + $urandom_range(0, 40);
      else if (pick < 95) s.tm = mdl_last_time + $urandom_range(0, 100000);
      else s.tm = $urandom;
      s.ok = ($urandom_range(0, 9) != 0);
      return s;
   endfunction

   // Result side: random back-pressure and field checks.
   always @(posedge clock) begin
      attitude_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_attitudes.size() == 0) begin
               $display("%0t: unexpected result roll=%h pitch=%h yaw=%h status=%b",
                        $time, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                        rsp_tuser);
               error_count++;
            end else begin
               want = pending_attitudes.pop_front();
               if (rsp_tdata[31:0] !== want.roll) begin
                  $display("%0t: roll expected %h actual %h", $time, want.roll,
                           rsp_tdata[31:0]);
                  error_count++;
               end
               if (rsp_tdata[63:32] !== want.pitch) begin
                  $display("%0t: pitch expected %h actual %h", $time, want.pitch,
                           rsp_tdata[63:32]);
                  error_count++;
               end
               if (rsp_tdata[95:64] !== want.yaw) begin
                  $display("%0t: yaw expected %h actual %h", $time, want.yaw,
                           rsp_tdata[95:64]);
                  error_count++;
               end
               if (rsp_tuser[0] !== want.st) begin
                  $display("%0t: status expected %b actual %b", $time, want.st,
                           rsp_tuser[0]);
                  error_count++;
               end
            end
         end
         rsp_tready <= rsp_busy_free ? 1'b1 : (pick_gap() == 0);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Reset, directed rows, then random phases under several weights.
   initial begin
      logic [15:0] phase_weights [NUM_PHASES];
      bit no_idle;
      phase_weights = '{16'd0, 16'd32768, 16'hFFFF, 16'd16384, 16'd32113};
      phase_weights[3] = $urandom_range(1, 32767);
      error_count = 0;
      cycle_count = 0;
      rsp_busy_free = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      rsp_tready = 1'b0;
      mdl_roll = 0;
      mdl_pitch = 0;
      mdl_yaw = 0;
      mdl_last_time = 0;
      mdl_weight = 16'd32113;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_ROWS; i++) begin
         send_sample(dir_rows[i], 1'b0);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_weight(phase_weights[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Stretches where neither side idles.
            no_idle = ((n / 40) % 3 == 1);
            rsp_busy_free = no_idle;
            send_sample(rand_sample(), no_idle);
         end
         rsp_busy_free = 1'b0;
      end

      req_tvalid <= 1'b0;
      while (pending_attitudes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
